// File: src/process_min_heap_scheduler_queue_core_assert.svh
// Assertion macros shared by the heap scheduler RTL
`ifndef PROCESS_MIN_HEAP_SCHEDULER_QUEUE_CORE_ASSERT_SVH
`define PROCESS_MIN_HEAP_SCHEDULER_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define PMHSQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define PMHSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pmhsq_pkg.sv
// Shared constants for the heap scheduler queue
`timescale 1ns / 1ps
package pmhsq_pkg;
    localparam int CAPACITY_DEF  = 64;
    localparam int TIME_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int PRIO_W        = 32;
    localparam int SLOT_W        = 6;
    localparam int FIELD_W       = 32;
    localparam int SIZE_W        = 7;
    localparam int ENTRY_W       = SLOT_W + PRIO_W;

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [PRIO_W-1:0] prio;
    } entry_t;
endpackage

// File: src/pmhsq_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module pmhsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: src/pmhsq_div.sv
// Restoring divider: floor(num * 2^FRAC_BITS / den), saturated to the priority width
`timescale 1ns / 1ps
module pmhsq_div #(
    parameter int TIME_BITS = pmhsq_pkg::TIME_BITS_DEF,
    parameter int FRAC_BITS = pmhsq_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [TIME_BITS-1:0]          num,
    input  logic [TIME_BITS-1:0]          den,
    output logic                          done,
    output logic [pmhsq_pkg::PRIO_W-1:0]  quotient
);
    localparam int TOT   = TIME_BITS + FRAC_BITS;
    localparam int CNT_W = $clog2(TOT + 1);
    localparam int PW    = pmhsq_pkg::PRIO_W;

    logic [TOT-1:0]       num_sh_reg;
    logic [TIME_BITS-1:0] rem_reg, den_reg;
    logic [PW-1:0]        quo_reg;
    logic                 sat_reg, busy_reg, done_reg;
    logic [CNT_W-1:0]     cnt_reg;

    logic [TIME_BITS:0]   r2;
    logic [TIME_BITS:0]   diff;
    logic                 ge;

    // One quotient bit per cycle
    assign r2   = {rem_reg, num_sh_reg[TOT-1]};
    assign ge   = r2 >= {1'b0, den_reg};
    assign diff = r2 - {1'b0, den_reg};

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(TOT);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_sh_reg <= {num, {FRAC_BITS{1'b0}}};
            den_reg    <= den;
            rem_reg    <= '0;
            quo_reg    <= '0;
            sat_reg    <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_sh_reg <= {num_sh_reg[TOT-2:0], 1'b0};
            rem_reg    <= ge ? diff[TIME_BITS-1:0] : r2[TIME_BITS-1:0];
            quo_reg    <= {quo_reg[PW-2:0], ge};
            sat_reg    <= sat_reg | quo_reg[PW-1];
        end
    end

    assign done     = done_reg;
    assign quotient = sat_reg ? {PW{1'b1}} : quo_reg;
endmodule

// File: src/process_min_heap_scheduler_queue_core.sv
// Top level of the min-heap process scheduler queue
// One command per transaction, one result per command. The heap lives in a
// single RAM with registered read, so each heap level costs a read-compare-write
// pass: UP_CHK and UP_CMP on sift-up, DN_CHK through DN_CMP on sift-down.
// A push with nonzero elapsed time first waits on the serial divider, and a
// push of a non-runnable process is appended at the tail with no sift-up.
// The next command is taken after the result transaction completes.
`timescale 1ns / 1ps
module process_min_heap_scheduler_queue_core #(
    parameter int CAPACITY  = pmhsq_pkg::CAPACITY_DEF,
    parameter int TIME_BITS = pmhsq_pkg::TIME_BITS_DEF,
    parameter int FRAC_BITS = pmhsq_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // proc_slot[5:0], run_ticks[37:6], creation_tick[69:38],
    // current_tick[101:70], runnable[102], previous_priority[134:103]
    input  logic [135:0] s_axis_tdata,
    // command[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // popped_slot[5:0], popped_priority[37:6], heap_size[44:38]
    output logic [47:0]  m_axis_tdata,
    // popped_valid[0], push_dropped[1]
    output logic [1:0]   m_axis_tuser
);
    `include "process_min_heap_scheduler_queue_core_assert.svh"

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = IW + 2;
    localparam int PW = pmhsq_pkg::PRIO_W;
    localparam int SW = pmhsq_pkg::SLOT_W;
    localparam int EW = pmhsq_pkg::ENTRY_W;
    localparam int ZW = pmhsq_pkg::SIZE_W;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DIV      = 4'd1;
    localparam logic [3:0] ST_PLACE    = 4'd2;
    localparam logic [3:0] ST_UP_CHK   = 4'd3;
    localparam logic [3:0] ST_UP_CMP   = 4'd4;
    localparam logic [3:0] ST_POP_ROOT = 4'd5;
    localparam logic [3:0] ST_POP_LAST = 4'd6;
    localparam logic [3:0] ST_DN_LOAD  = 4'd7;
    localparam logic [3:0] ST_DN_CHK   = 4'd8;
    localparam logic [3:0] ST_DN_LEFT  = 4'd9;
    localparam logic [3:0] ST_DN_RIGHT = 4'd10;
    localparam logic [3:0] ST_DN_CMP   = 4'd11;
    localparam logic [3:0] ST_OUT      = 4'd12;

    // Input field unpacking
    logic [1:0]                     command;
    logic [SW-1:0]                  proc_slot;
    logic [pmhsq_pkg::FIELD_W-1:0]  run_ticks, creation_tick, current_tick;
    logic                           runnable;
    logic [PW-1:0]                  previous_priority;
    logic [TIME_BITS-1:0]           num_ticks, elapsed;

    assign command           = s_axis_tuser;
    assign proc_slot         = s_axis_tdata[5:0];
    assign run_ticks         = s_axis_tdata[37:6];
    assign creation_tick     = s_axis_tdata[69:38];
    assign current_tick      = s_axis_tdata[101:70];
    assign runnable          = s_axis_tdata[102];
    assign previous_priority = s_axis_tdata[134:103];
    assign num_ticks         = TIME_BITS'(run_ticks);
    assign elapsed           = TIME_BITS'(current_tick) - TIME_BITS'(creation_tick);

    // State
    logic [3:0]        state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [IW-1:0]     best_idx_reg, best_idx_next;
    pmhsq_pkg::entry_t cur_reg, cur_next;
    pmhsq_pkg::entry_t best_reg, best_next;
    logic              run_reg, run_next;
    logic              pv_reg, pv_next;
    logic              pd_reg, pd_next;
    pmhsq_pkg::entry_t pe_reg, pe_next;

    // Memory and divider hookup
    logic              mem_we;
    logic [IW-1:0]     mem_waddr, mem_raddr;
    pmhsq_pkg::entry_t mem_wdata, mem_rdata;
    logic [EW-1:0]     mem_rbits;
    logic              div_start, div_done;
    logic [PW-1:0]     div_quo;

    pmhsq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rbits)
    );
    assign mem_rdata = mem_rbits;

    pmhsq_div #(.TIME_BITS(TIME_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (num_ticks),
        .den      (elapsed),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Heap index arithmetic
    logic [XW-1:0] left_x, right_x, cnt_x;
    logic [IW-1:0] parent_idx;
    logic          full;

    assign left_x     = {1'b0, idx_reg, 1'b1};
    assign right_x    = left_x + 1'b1;
    assign cnt_x      = XW'(cnt_reg);
    assign parent_idx = IW'((idx_reg - 1'b1) >> 1);
    assign full       = cnt_reg == CW'(CAPACITY);

    assign s_axis_tready = state_reg == ST_IDLE;

    // Command sequencer
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        best_idx_next = best_idx_reg;
        cur_next      = cur_reg;
        best_next     = best_reg;
        run_next      = run_reg;
        pv_next       = pv_reg;
        pd_next       = pd_reg;
        pe_next       = pe_reg;
        mem_we        = 1'b0;
        mem_waddr     = idx_reg;
        mem_wdata     = cur_reg;
        mem_raddr     = '0;
        div_start     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    pv_next = 1'b0;
                    pd_next = 1'b0;
                    pe_next = '0;
                    case (command)
                        pmhsq_pkg::CMD_PUSH:
                        begin
                            cur_next.slot = proc_slot;
                            cur_next.prio = previous_priority;
                            run_next      = runnable;
                            if (full)
                            begin
                                pd_next    = 1'b1;
                                state_next = ST_OUT;
                            end
                            else if (elapsed != '0)
                            begin
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                            else
                            begin
                                state_next = ST_PLACE;
                            end
                        end
                        pmhsq_pkg::CMD_POP:
                        begin
                            state_next = (cnt_reg == '0) ? ST_OUT : ST_POP_ROOT;
                        end
                        pmhsq_pkg::CMD_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = ST_OUT;
                        end
                        default:
                        begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    cur_next.prio = div_quo;
                    state_next    = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                // Append at the tail
                idx_next = cnt_reg[IW-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (!run_reg || cnt_reg == '0)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = cnt_reg[IW-1:0];
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_UP_CHK;
                end
            end
            ST_UP_CHK:
            begin
                if (idx_reg == '0)
                begin
                    mem_we     = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    mem_raddr  = parent_idx;
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP:
            begin
                // Move parent down while it is strictly greater
                mem_we = 1'b1;
                if (mem_rdata.prio > cur_reg.prio)
                begin
                    mem_wdata  = mem_rdata;
                    idx_next   = parent_idx;
                    state_next = ST_UP_CHK;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_POP_ROOT:
            begin
                mem_raddr  = '0;
                state_next = ST_POP_LAST;
            end
            ST_POP_LAST:
            begin
                pv_next    = 1'b1;
                pe_next    = mem_rdata;
                mem_raddr  = IW'(cnt_reg - 1'b1);
                cnt_next   = cnt_reg - 1'b1;
                state_next = (cnt_reg == CW'(1)) ? ST_OUT : ST_DN_LOAD;
            end
            ST_DN_LOAD:
            begin
                cur_next   = mem_rdata;
                idx_next   = '0;
                state_next = ST_DN_CHK;
            end
            ST_DN_CHK:
            begin
                if (left_x >= cnt_x)
                begin
                    mem_we     = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    mem_raddr  = left_x[IW-1:0];
                    state_next = ST_DN_LEFT;
                end
            end
            ST_DN_LEFT:
            begin
                best_next     = mem_rdata;
                best_idx_next = left_x[IW-1:0];
                if (right_x < cnt_x)
                begin
                    mem_raddr  = right_x[IW-1:0];
                    state_next = ST_DN_RIGHT;
                end
                else
                begin
                    state_next = ST_DN_CMP;
                end
            end
            ST_DN_RIGHT:
            begin
                // Ties stay with the left child
                if (mem_rdata.prio < best_reg.prio)
                begin
                    best_next     = mem_rdata;
                    best_idx_next = right_x[IW-1:0];
                end
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP:
            begin
                mem_we = 1'b1;
                if (cur_reg.prio > best_reg.prio)
                begin
                    mem_wdata  = best_reg;
                    idx_next   = best_idx_reg;
                    state_next = ST_DN_CHK;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        best_idx_reg <= best_idx_next;
        cur_reg      <= cur_next;
        best_reg     <= best_next;
        run_reg      <= run_next;
        pv_reg       <= pv_next;
        pd_reg       <= pd_next;
        pe_reg       <= pe_next;
    end

    // Result transaction
    assign m_axis_tvalid = state_reg == ST_OUT;
    assign m_axis_tdata  = {3'b000, ZW'(cnt_reg), pe_reg.prio, pe_reg.slot};
    assign m_axis_tuser  = {pd_reg, pv_reg};

    // Checks
    `PMHSQ_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CW'(CAPACITY), "count overflow")
    `PMHSQ_ASSERT_NOW(a_one_side, clk, rst_n, m_axis_tvalid, !s_axis_tready, "input open with result pending")
    `PMHSQ_ASSERT_NEXT(a_full_drop, clk, rst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser == pmhsq_pkg::CMD_PUSH && full, m_axis_tvalid && pd_reg && $stable(cnt_reg), "full push not dropped")
    `PMHSQ_ASSERT_NOW(a_pop_empty, clk, rst_n, m_axis_tvalid && !pv_reg, pe_reg.prio == '0 && pe_reg.slot == '0, "stale popped entry")
endmodule

// File: dv/tb_process_min_heap_scheduler_queue_core.sv
// Testbench for the min-heap process scheduler queue: directed table, a fill past capacity, then random commands
`timescale 1ns / 1ps
module tb_process_min_heap_scheduler_queue_core;
    localparam int CAP = pmhsq_pkg::CAPACITY_DEF;
    localparam int LIMIT = 2000000;

    typedef struct {
        logic [1:0]  cmd;
        logic [5:0]  slot;
        logic [31:0] run_t;
        logic [31:0] born;
        logic [31:0] now;
        logic        runnable;
        logic [31:0] prev_prio;
    } sched_cmd_t;

    typedef struct packed {
        logic        pvalid;
        logic [5:0]  pslot;
        logic [31:0] pprio;
        logic        dropped;
        logic [6:0]  size;
    } sched_res_t;

    // Directed row: command plus an optional typed-in expectation
    typedef struct {
        sched_cmd_t c;
        bit         fixed;
        sched_res_t r;
    } table_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    process_min_heap_scheduler_queue_core DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    // Predictor state
    logic [5:0]  heap_slot [CAP];
    logic [31:0] heap_prio [CAP];
    int          heap_count;

    sched_res_t  pending_results[$];
    table_row_t  dir_rows[$];
    sched_res_t  last_want;
    int          errors;
    int          mismatches;
    int          cycles;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_off;

    initial begin
        clk = 1'b0;
    end
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Fixed-point divide with saturation, restoring, 33-bit remainder
    function automatic logic [31:0] prio_divide(logic [31:0] num, logic [31:0] den);
        logic [47:0] dividend;
        logic [32:0] rem;
        logic [47:0] quo;
        dividend = {num, 16'h0};
        rem = '0;
        quo = '0;
        for (int i = 47; i >= 0; i--)
        begin
            rem = {rem[31:0], dividend[i]};
            quo = quo << 1;
            if (rem >= {1'b0, den})
            begin
                rem = rem - {1'b0, den};
                quo[0] = 1'b1;
            end
        end
        if (quo > 48'hFFFF_FFFF)
            return 32'hFFFF_FFFF;
        return quo[31:0];
    endfunction

    function automatic void swap_slots(int a, int b);
        logic [5:0]  ts;
        logic [31:0] tp;
        ts = heap_slot[a]; heap_slot[a] = heap_slot[b]; heap_slot[b] = ts;
        tp = heap_prio[a]; heap_prio[a] = heap_prio[b]; heap_prio[b] = tp;
    endfunction

    function automatic sched_res_t schedule_step(sched_cmd_t c);
        sched_res_t  r;
        logic [31:0] elapsed;
        logic [31:0] prio;
        int idx, par, l, rt, m;
        r = '0;
        if (c.cmd == pmhsq_pkg::CMD_PUSH)
        begin
            elapsed = c.now - c.born;
            prio = (elapsed != 0) ? prio_divide(c.run_t, elapsed) : c.prev_prio;
            if (heap_count < CAP)
            begin
                idx = heap_count;
                heap_slot[idx] = c.slot;
                heap_prio[idx] = prio;
                if (c.runnable)
                begin
                    while (idx > 0)
                    begin
                        par = (idx - 1) / 2;
                        if (heap_prio[par] > heap_prio[idx])
                        begin
                            swap_slots(par, idx);
                            idx = par;
                        end
                        else
                            break;
                    end
                end
                heap_count++;
            end
            else
                r.dropped = 1'b1;
        end
        else if (c.cmd == pmhsq_pkg::CMD_POP)
        begin
            if (heap_count > 0)
            begin
                r.pvalid = 1'b1;
                r.pslot = heap_slot[0];
                r.pprio = heap_prio[0];
                heap_count--;
                heap_slot[0] = heap_slot[heap_count];
                heap_prio[0] = heap_prio[heap_count];
                idx = 0;
                forever
                begin
                    l = 2 * idx + 1;
                    rt = 2 * idx + 2;
                    if (l >= heap_count)
                        break;
                    if (rt >= heap_count)
                        m = l;
                    else
                        m = (heap_prio[l] <= heap_prio[rt]) ? l : rt;
                    if (heap_prio[idx] > heap_prio[m])
                    begin
                        swap_slots(idx, m);
                        idx = m;
                    end
                    else
                        break;
                end
            end
        end
        else if (c.cmd == pmhsq_pkg::CMD_CLEAR)
            heap_count = 0;
        r.size = heap_count[6:0];
        return r;
    endfunction

    function automatic sched_cmd_t mk_cmd(logic [1:0] cmd, logic [5:0] slot, logic [31:0] run_t,
                                          logic [31:0] born, logic [31:0] now, logic runnable,
                                          logic [31:0] prev_prio);
        sched_cmd_t c;
        c.cmd = cmd; c.slot = slot; c.run_t = run_t; c.born = born; c.now = now;
        c.runnable = runnable; c.prev_prio = prev_prio;
        return c;
    endfunction

    function automatic sched_cmd_t rand_cmd();
        sched_cmd_t c;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            c.cmd = pmhsq_pkg::CMD_PUSH;
        else if (sel < 93)
            c.cmd = pmhsq_pkg::CMD_POP;
        else if (sel < 96)
            c.cmd = pmhsq_pkg::CMD_NOP;
        else
            c.cmd = pmhsq_pkg::CMD_CLEAR;
        c.slot = 6'($urandom);
        c.run_t = $urandom;
        c.born = $urandom;
        case ($urandom_range(0, 4))
            0: c.now = c.born;
            1: c.now = c.born + $urandom_range(1, 1000);
            2: c.now = c.born + 1;
            default: c.now = $urandom;
        endcase
        if ($urandom_range(0, 3) != 0)
            c.run_t = c.run_t >> $urandom_range(0, 31);
        c.runnable = ($urandom_range(0, 9) != 0);
        c.prev_prio = $urandom;
        return c;
    endfunction

    // Directed table: reset, extremes, special cases
    task automatic build_table();
        table_row_t row;
        sched_res_t z;
        z = '0;
        row.fixed = 1'b1;
        row.c = mk_cmd(pmhsq_pkg::CMD_POP, 0, 0, 0, 0, 0, 0); row.r = z; dir_rows.push_back(row);
        row.c = mk_cmd(pmhsq_pkg::CMD_NOP, 6'h3F, '1, '1, '1, 1, '1);
        row.r = z; dir_rows.push_back(row);
        // zero elapsed: previous priority kept
        row.c = mk_cmd(pmhsq_pkg::CMD_PUSH, 6'h3F, '1, 32'h1234, 32'h1234, 1, 32'hFFFF_FFFF);
        row.r = z; row.r.size = 1; dir_rows.push_back(row);
        row.c = mk_cmd(pmhsq_pkg::CMD_POP, 0, 0, 0, 0, 0, 0);
        row.r = z; row.r.pvalid = 1; row.r.pslot = 6'h3F; row.r.pprio = 32'hFFFF_FFFF;
        dir_rows.push_back(row);
        // saturation: max running time over one tick
        row.c = mk_cmd(pmhsq_pkg::CMD_PUSH, 1, '1, 32'hFFFF_FFFF, 32'h0, 1, 0);
        row.r = z; row.r.size = 1; dir_rows.push_back(row);
        row.c = mk_cmd(pmhsq_pkg::CMD_POP, 0, 0, 0, 0, 0, 0);
        row.r = z; row.r.pvalid = 1; row.r.pslot = 1; row.r.pprio = 32'hFFFF_FFFF;
        dir_rows.push_back(row);
        row.fixed = 1'b0;
        row.r = z;
        row.c = mk_cmd(pmhsq_pkg::CMD_PUSH, 2, 0, 0, '1, 1, '1); dir_rows.push_back(row);
        row.c = mk_cmd(pmhsq_pkg::CMD_PUSH, 3, 32'd100, 0, 32'd7, 1, 0); dir_rows.push_back(row);
        row.c = mk_cmd(pmhsq_pkg::CMD_PUSH, 4, 32'd100, 0, 32'd7, 1, 0); dir_rows.push_back(row);
        // non-runnable push leaves heap out of order
        row.c = mk_cmd(pmhsq_pkg::CMD_PUSH, 5, 32'd1, 0, 32'd1000, 0, 0); dir_rows.push_back(row);
        row.c = mk_cmd(pmhsq_pkg::CMD_PUSH, 6, '1, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0);
        dir_rows.push_back(row);
        for (int i = 0; i < 5; i++)
        begin
            row.c = mk_cmd(pmhsq_pkg::CMD_POP, 0, 0, 0, 0, 0, 0); dir_rows.push_back(row);
        end
        row.fixed = 1'b1;
        row.c = mk_cmd(pmhsq_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0); row.r = z; dir_rows.push_back(row);
    endtask

    // Drive one command transaction; entered and left at a falling edge
    task automatic send_cmd(sched_cmd_t c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.cmd;
        s_axis_tdata  <= {1'b0, c.prev_prio, c.runnable, c.now, c.born, c.run_t, c.slot};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        // Predict at acceptance, in acceptance order
        last_want = schedule_step(c);
        pending_results.push_back(last_want);
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // Compare results
    always @(posedge clk)
    begin
        sched_res_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.pslot = m_axis_tdata[5:0];
            got.pprio = m_axis_tdata[37:6];
            got.size = m_axis_tdata[44:38];
            got.pvalid = m_axis_tuser[0];
            got.dropped = m_axis_tuser[1];
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result slot=%0d prio=%h size=%0d",
                             got.pslot, got.pprio, got.size);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: exp v=%b s=%0d p=%h d=%b n=%0d ",
                                  "got v=%b s=%0d p=%h d=%b n=%0d"},
                                 want.pvalid, want.pslot, want.pprio, want.dropped, want.size,
                                 got.pvalid, got.pslot, got.pprio, got.dropped, got.size);
                end
            end
        end
    end

    // Receiver ready, with random idling and a long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        table_row_t row;
        errors = 0; mismatches = 0; cycles = 0; heap_count = 0;
        hold_off = 1'b0;
        send_idle_pct = 12; recv_idle_pct = 51;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = pmhsq_pkg::CMD_NOP;
        m_axis_tready = 1'b0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table; fixed rows also check the predictor itself
        build_table();
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            send_cmd(row.c);
            if (row.fixed && last_want !== row.r)
            begin
                errors++;
                $display("ERROR: directed row %0d predicted result differs from table", i);
            end
        end
        drain();

        // Fill to capacity and push past it, with the receiver held off
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(negedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < CAP + 3; i++)
                    send_cmd(mk_cmd(pmhsq_pkg::CMD_PUSH, 6'(i), $urandom, 0,
                                    $urandom_range(1, 9), 1, 0));
            end
        join
        for (int i = 0; i < CAP + 1; i++)
            send_cmd(mk_cmd(pmhsq_pkg::CMD_POP, 0, 0, 0, 0, 0, 0));
        drain();

        // Random phases with three idling profiles
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 51 : 0;
            recv_idle_pct = (ph == 0) ? 51 : (ph == 1) ? 12 : 0;
            for (int i = 0; i < 110; i++)
                send_cmd(rand_cmd());
            drain();
        end

        if (errors == 0 && mismatches == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
